// File: rtl/core/csim_pkg.sv
// ----------------------------------------------------------------------------
// csim_pkg
// shared widths and types of the cosine similarity engine
// ----------------------------------------------------------------------------
package csim_pkg;

  localparam int ELEM_W     = 16;
  localparam int EPROD_W    = 32;
  localparam int SQ_W       = 31;
  localparam int DOT_W      = 42;
  localparam int NORM_W     = 41;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [NORM_W-1:0] norm_a;
    logic [NORM_W-1:0] norm_b;
  } csim_sums_t;

  typedef struct packed {
    logic       valid;
    csim_sums_t sums;
  } csim_push_t;

endpackage

// File: rtl/core/csim_front.sv
// ----------------------------------------------------------------------------
// csim_front
// accepts element pairs, accumulates dot product and norms, queues sums
// ----------------------------------------------------------------------------
module csim_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [csim_pkg::ELEM_W-1:0]      elem_a_i,
  input  logic signed [csim_pkg::ELEM_W-1:0]      elem_b_i,
  input  logic                                    last_element_i,
  input  logic        [csim_pkg::FIFO_CNT_W-1:0]  fifo_cnt_i,
  output csim_pkg::csim_push_t                    push_o
);
  import csim_pkg::*;

  logic signed [EPROD_W-1:0] p_ab, p_aa, p_bb;
  logic                      s1_valid_q, s1_last_q;
  logic signed [EPROD_W-1:0] dot_p_q;
  logic        [SQ_W-1:0]    aa_q, bb_q;
  logic        [DOT_W-1:0]   dot_q, dot_d;
  logic        [NORM_W-1:0]  na_q, na_d, nb_q, nb_d;
  logic        [FIFO_CNT_W:0] occ;
  logic                      accept;

  assign p_ab = elem_a_i * elem_b_i;
  assign p_aa = elem_a_i * elem_a_i;
  assign p_bb = elem_b_i * elem_b_i;

  assign occ = {1'b0, fifo_cnt_i} + (FIFO_CNT_W+1)'(s1_valid_q & s1_last_q);
  assign in_ready_o = occ < (FIFO_CNT_W+1)'(FIFO_DEPTH);
  assign accept = in_valid_i & in_ready_o;

  assign dot_d = dot_q + {{(DOT_W-EPROD_W){dot_p_q[EPROD_W-1]}}, dot_p_q};
  assign na_d  = na_q + {{(NORM_W-SQ_W){1'b0}}, aa_q};
  assign nb_d  = nb_q + {{(NORM_W-SQ_W){1'b0}}, bb_q};

  assign push_o.valid       = s1_valid_q & s1_last_q;
  assign push_o.sums.dot    = dot_d;
  assign push_o.sums.norm_a = na_d;
  assign push_o.sums.norm_b = nb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      dot_q      <= '0;
      na_q       <= '0;
      nb_q       <= '0;
    end else begin
      s1_valid_q <= accept;
      s1_last_q  <= last_element_i;
      if (s1_valid_q) begin
        if (s1_last_q) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
        end else begin
          dot_q <= dot_d;
          na_q  <= na_d;
          nb_q  <= nb_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dot_p_q <= p_ab;
    aa_q    <= p_aa[SQ_W-1:0];
    bb_q    <= p_bb[SQ_W-1:0];
  end

endmodule

// File: rtl/core/csim_fifo.sv
// ----------------------------------------------------------------------------
// csim_fifo
// short queue of closed vector sums between front and back
// ----------------------------------------------------------------------------
module csim_fifo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  csim_pkg::csim_push_t                   push_i,
  input  logic                                   pop_i,
  output logic                                   avail_o,
  output csim_pkg::csim_sums_t                   data_o,
  output logic       [csim_pkg::FIFO_CNT_W-1:0]  cnt_o
);
  import csim_pkg::*;

  csim_sums_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign avail_o = cnt_q != '0;
  assign do_pop  = pop_i & avail_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)       rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i.valid) - FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_ptr_q] <= push_i.sums;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> cnt_q != FIFO_CNT_W'(FIFO_DEPTH)) else $error("fifo overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH)) else $error("fifo count out of range");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_ptr_q == rd_ptr_q) else $error("empty fifo with split pointers");
`endif

endmodule

// File: rtl/core/csim_back.sv
// ----------------------------------------------------------------------------
// csim_back
// zero-norm check, norm product, integer square root, division and saturation per vector
// ----------------------------------------------------------------------------
module csim_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  avail_i,
  input  csim_pkg::csim_sums_t                  data_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [csim_pkg::ELEM_W-1:0]    similarity_o,
  output logic                                  zero_norm_o
);
  import csim_pkg::*;

  localparam int HALF_W = 21;
  localparam int HPROD_W = 2 * HALF_W;
  localparam int PROD_W = 2 * NORM_W;
  localparam int REM_W = NORM_W + 3;
  localparam int DREM_W = NORM_W + 1;
  localparam int QB = 15;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SQRT, ST_DIV, ST_DONE} state_e;

  state_e                 state_q;
  logic [5:0]             cnt_q;
  logic [NORM_W-1:0]      na_q, nb_q;
  logic [DOT_W-1:0]       mag_q;
  logic                   neg_q, sat_q;
  logic [HPROD_W-1:0]     prod_q;
  logic [5:0]             sh_q;
  logic [PROD_W-1:0]      acc_q;
  logic [REM_W-1:0]       rem_q;
  logic [NORM_W-1:0]      root_q;
  logic [DREM_W-1:0]      drem_q;
  logic [QB-1:0]          quo_q;
  logic                   res_zero_q;
  logic [ELEM_W-1:0]      res_sim_q;
  logic                   out_valid_q, zero_q;
  logic [ELEM_W-1:0]      sim_q;

  logic [HALF_W-1:0]      op_a, op_b;
  logic [PROD_W-1:0]      acc_d;
  logic [REM_W-1:0]       rem_sh, trial;
  logic                   sq_ge;
  logic [NORM_W-1:0]      root_d;
  logic [DREM_W-1:0]      d2;
  logic                   dv_ge;
  logic [QB-1:0]          quo_d;
  logic [ELEM_W-1:0]      q16, sim_res;
  logic [DOT_W-1:0]       mag_in;

  assign pop_o = (state_q == ST_IDLE) & avail_i;
  assign mag_in = data_i.dot[DOT_W-1] ? (DOT_W'(0) - data_i.dot) : data_i.dot;

  always_comb begin
    op_a = cnt_q[0] ? HALF_W'(na_q[NORM_W-1:HALF_W]) : na_q[HALF_W-1:0];
    op_b = cnt_q[1] ? HALF_W'(nb_q[NORM_W-1:HALF_W]) : nb_q[HALF_W-1:0];
    acc_d = acc_q + (PROD_W'(prod_q) << sh_q);
    rem_sh = {rem_q[REM_W-3:0], acc_q[PROD_W-1:PROD_W-2]};
    trial = {1'b0, root_q, 2'b01};
    sq_ge = rem_sh >= trial;
    root_d = {root_q[NORM_W-2:0], sq_ge};
    d2 = {drem_q[DREM_W-2:0], 1'b0};
    dv_ge = d2 >= {1'b0, root_q};
    quo_d = {quo_q[QB-2:0], dv_ge};
    q16 = {1'b0, quo_d};
    if (neg_q) sim_res = sat_q ? 16'h8000 : (ELEM_W'(0) - q16);
    else       sim_res = sat_q ? 16'h7fff : q16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (avail_i) begin
            na_q  <= data_i.norm_a;
            nb_q  <= data_i.norm_b;
            mag_q <= mag_in;
            neg_q <= data_i.dot[DOT_W-1];
            cnt_q <= '0;
            acc_q <= '0;
            if (data_i.norm_a == '0 || data_i.norm_b == '0) begin
              res_zero_q <= 1'b1;
              res_sim_q  <= '0;
              state_q    <= ST_DONE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q <= op_a * op_b;
          sh_q   <= (cnt_q[0] ^ cnt_q[1]) ? 6'd21 : (cnt_q[1] ? 6'd42 : 6'd0);
          if (cnt_q != '0) acc_q <= acc_d;
          if (cnt_q == 6'd4) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            root_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SQRT: begin
          rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
          root_q <= root_d;
          acc_q  <= acc_q << 2;
          if (cnt_q == 6'(NORM_W - 1)) begin
            cnt_q   <= '0;
            sat_q   <= mag_q >= {1'b0, root_d};
            drem_q  <= mag_q[DREM_W-1:0];
            quo_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          drem_q <= dv_ge ? d2 - {1'b0, root_q} : d2;
          quo_q  <= quo_d;
          if (cnt_q == 6'(QB - 1)) begin
            res_zero_q <= 1'b0;
            res_sim_q  <= sim_res;
            state_q    <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            sim_q       <= res_sim_q;
            zero_q      <= res_zero_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zero_q;

`ifndef ASSERT_OFF
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> root_q != '0) else $error("zero root in divide");
  a_zero_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && zero_q |-> sim_q == '0) else $error("zero norm with nonzero result");
  a_mul_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_MUL || state_q == ST_SQRT)
    else $error("bad exit from multiply");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q != ST_IDLE) else $error("pop without starting");
`endif

endmodule

// File: rtl/core/cosine_similarity_engine_core.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_core
// streaming cosine similarity of two vectors, result in Q1.15
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid_i/in_ready_o | elem_a_i, elem_b_i, last_element_i
//   out     | out | out_valid_o/out_ready_i | similarity_o, zero_norm_o
//
// element pairs are taken one per cycle while the sums queue has room
// per vector the back end forms the norm product, takes the bit-serial
// square root and the divide, then loads the output
// short vectors stall the input once two closed vectors wait in the queue
// reset clears accumulators, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
module cosine_similarity_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [csim_pkg::ELEM_W-1:0]  elem_a_i,
  input  logic signed [csim_pkg::ELEM_W-1:0]  elem_b_i,
  input  logic                                last_element_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [csim_pkg::ELEM_W-1:0]  similarity_o,
  output logic                                zero_norm_o
);
  import csim_pkg::*;

  csim_push_t            push;
  csim_sums_t            fifo_data;
  logic                  fifo_avail, pop;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  csim_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .elem_a_i, .elem_b_i,
    .last_element_i, .fifo_cnt_i(fifo_cnt), .push_o(push)
  );

  csim_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .pop_i(pop), .avail_o(fifo_avail),
    .data_o(fifo_data), .cnt_o(fifo_cnt)
  );

  csim_back u_back (
    .clk_i, .rst_ni, .avail_i(fifo_avail), .data_i(fifo_data), .pop_o(pop),
    .out_valid_o, .out_ready_i, .similarity_o, .zero_norm_o
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming cosine similarity engine: random and
// directed element pairs go in, each closed vector's Q1.15 result is predicted
// and compared against the output stream
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csim_pkg::*;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     last;
  } pair_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sim;
    logic                     zn;
  } sim_t;

  localparam int LIMIT_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [ELEM_W-1:0] elem_a_i = '0;
  logic signed [ELEM_W-1:0] elem_b_i = '0;
  logic last_element_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [ELEM_W-1:0] similarity_o;
  logic zero_norm_o;

  pair_t pending_pairs[$];
  sim_t  expected_sims[$];
  logic [DOT_W-1:0]  dot_acc = '0;
  logic [NORM_W-1:0] na_acc = '0;
  logic [NORM_W-1:0] nb_acc = '0;
  int errors = 0;
  int n_pairs = 0;
  int n_results = 0;
  int n_zero = 0;
  int n_sat = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  cosine_similarity_engine_core DUT (.*);

  function automatic logic [40:0] isqrt82(logic [81:0] v);
    logic [40:0] r;
    logic [40:0] c;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      c = r | (41'd1 << i);
      if ({41'd0, c} * {41'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // accumulate one pair, return 1 with a result on the closing pair
  function automatic bit accumulate_pair(pair_t p, output sim_t s);
    logic signed [41:0] pa, pb;
    logic [81:0] prod;
    logic [41:0] root;
    logic [41:0] mag;
    logic [56:0] q;
    bit neg;
    pa = p.a;
    pb = p.b;
    dot_acc = dot_acc + pa * pb;
    na_acc = na_acc + NORM_W'(pa * pa);
    nb_acc = nb_acc + NORM_W'(pb * pb);
    s = '0;
    if (!p.last) return 0;
    if (na_acc == 0 || nb_acc == 0) begin
      s.zn = 1'b1;
    end else begin
      prod = {41'd0, na_acc} * {41'd0, nb_acc};
      root = {1'b0, isqrt82(prod)};
      if (root == 0) root = 1;
      neg = dot_acc[DOT_W-1];
      mag = neg ? -dot_acc : dot_acc;
      q = ({15'd0, mag} << 15) / {15'd0, root};
      if (neg) begin
        if (q > 32768) q = 32768;
        s.sim = 16'(17'h10000 - q[16:0]);
      end else begin
        if (q > 32767) q = 32767;
        s.sim = q[15:0];
      end
    end
    dot_acc = '0;
    na_acc = '0;
    nb_acc = '0;
    return 1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem(int mode);
    case (mode)
      0: return ELEM_W'($urandom);
      1: return ELEM_W'($urandom_range(0, 15)) - 16'sd8;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return '0;
    endcase
  endfunction

  task automatic push_vec(int len, int mode, int kind);
    pair_t p;
    for (int i = 0; i < len; i++) begin
      p.a = rand_elem(mode);
      case (kind)
        1: p.b = p.a;
        2: p.b = -p.a;
        3: p.b = '0;
        default: p.b = rand_elem(mode);
      endcase
      p.last = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  initial begin
    pair_t p;
    // extremes, zero norms, saturation and sign cases
    pending_pairs.push_back('{16'sh7fff, 16'sh7fff, 1'b1});
    pending_pairs.push_back('{16'sh8000, 16'sh8000, 1'b1});
    pending_pairs.push_back('{16'sh8000, 16'sh7fff, 1'b1});
    pending_pairs.push_back('{16'sh7fff, 16'sh8000, 1'b1});
    pending_pairs.push_back('{16'sh0000, 16'sh1234, 1'b1});
    pending_pairs.push_back('{16'sh5555, 16'sh0000, 1'b1});
    pending_pairs.push_back('{16'sh0000, 16'sh0000, 1'b1});
    pending_pairs.push_back('{16'sh0001, 16'shffff, 1'b1});
    pending_pairs.push_back('{16'sh0003, 16'sh0004, 1'b0});
    pending_pairs.push_back('{16'sh0004, 16'shfffd, 1'b1});
    pending_pairs.push_back('{16'sh0001, 16'sh0001, 1'b0});
    pending_pairs.push_back('{16'sh0001, 16'sh0000, 1'b1});
    pending_pairs.push_back('{16'shaaaa, 16'sh5555, 1'b0});
    pending_pairs.push_back('{16'sh5555, 16'shaaaa, 1'b1});
    push_vec(5, 2, 1);
    push_vec(4, 2, 2);
    // long full-scale vector grows the sums past 2^40 without wrapping the accumulators
    push_vec(1100, 2, 1);
    while (pending_pairs.size() < 1950) begin
      case ($urandom_range(0, 9))
        0: push_vec($urandom_range(1, 3), 0, $urandom_range(0, 3));
        1: push_vec($urandom_range(1, 8), 1, $urandom_range(0, 3));
        2: push_vec($urandom_range(1, 6), 2, $urandom_range(0, 2));
        default: push_vec($urandom_range(1, 12), 0, 0);
      endcase
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    sim_t s;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        n_pairs++;
        if (accumulate_pair({elem_a_i, elem_b_i, last_element_i}, s)) begin
          expected_sims.push_back(s);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          {elem_a_i, elem_b_i, last_element_i} <= pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sim_t e;
    cycles++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_sims.size() == 0) begin
          $error("result with nothing expected: sim %0d", similarity_o);
          errors++;
        end else begin
          e = expected_sims.pop_front();
          if (e.zn) n_zero++;
          if (e.sim == 16'sh7fff || e.sim == 16'sh8000) n_sat++;
          if (similarity_o !== e.sim) begin
            $error("similarity: expected %0d actual %0d", e.sim, similarity_o);
            errors++;
          end
          if (zero_norm_o !== e.zn) begin
            $error("zero_norm: expected %0d actual %0d", e.zn, zero_norm_o);
            errors++;
          end
        end
      end
      if (n_pairs > 1400 && n_pairs < 1500 && hold_off == 0) hold_off = 3000;
      if (hold_off > 1) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (gap_len() == 0);
      end
    end
  end

  initial begin
    wait (stim_done && !in_valid_i);
    while (expected_sims.size() != 0 && cycles < LIMIT_CYCLES) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d pairs in, %0d vectors checked (%0d zero norm, %0d at full scale)",
             n_pairs, n_results, n_zero, n_sat);
    if (errors == 0 && expected_sims.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

endmodule
